[src/tlb_page_table_translator_defines.svh]
// ---------------------------------------------------------------------------
// TLB page table translator: assertion macros
// Shared concurrent assertion wrappers; empty when building for synthesis.
// ---------------------------------------------------------------------------
`ifndef TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every edge outside reset.
`define TPT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true outside reset.
`define TPT_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define TPT_ASSERT(lbl, clk, rst, prop, msg)
`define TPT_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

[src/tpt_pkg.sv]
// ---------------------------------------------------------------------------
// TLB page table translator package
// Field widths and the records passed between the translator's units.
// ---------------------------------------------------------------------------
`default_nettype none

package tpt_pkg;

   localparam int VA_W     = 16;
   localparam int PAGE_W   = 8;
   localparam int OFFSET_W = 8;
   localparam int FRAME_W  = 8;
   localparam int CNT_W    = 16;
   localparam int NFF_W    = 9;   // free-frame counter, reaches FRAME_SPAN
   localparam int FRAME_SPAN = 256;
   localparam int PAGE_SPAN  = 256;

   // One page map entry as it sits in memory.
   typedef struct packed {
      logic               valid;
      logic [FRAME_W-1:0] frame;
   } map_entry_type;

   localparam int MAP_ENTRY_W = $bits(map_entry_type);

   // TLB lookup answer.
   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] frame;
   } tlb_lookup_type;

   // TLB fill into the FIFO slot.
   typedef struct packed {
      logic               en;
      logic [PAGE_W-1:0]  page;
      logic [FRAME_W-1:0] frame;
   } tlb_fill_type;

endpackage

`default_nettype wire

[src/tpt_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with enable and registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module tpt_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 256
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/tpt_pmap.sv]
// ---------------------------------------------------------------------------
// Page map store
// Page map RAM with a clearing sweep after reset and a write-to-read bypass.
// ---------------------------------------------------------------------------
`default_nettype none

module tpt_pmap #(
   parameter int PAGE_COUNT = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           rd_en,
   input  wire logic [$clog2(PAGE_COUNT)-1:0]  rd_addr,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(PAGE_COUNT)-1:0]  wr_addr,
   input  wire tpt_pkg::map_entry_type         wr_entry,
   output tpt_pkg::map_entry_type              rd_entry,
   output logic                                clearing
);
   import tpt_pkg::*;

   localparam int MAP_AW = $clog2(PAGE_COUNT);

   logic              clr_active_ff, clr_active_in;
   logic [MAP_AW-1:0] clr_idx_ff, clr_idx_in;
   logic              byp_ff, byp_in;
   map_entry_type     byp_entry_ff;
   logic              ram_wr_en;
   logic [MAP_AW-1:0] ram_wr_addr;
   map_entry_type     ram_wr_entry;
   logic [MAP_ENTRY_W-1:0] ram_rd_data;

   // Sweep writes one invalid entry per cycle until the last index.
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_idx_in    = clr_idx_ff;
      if (clr_active_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == MAP_AW'(PAGE_COUNT - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_comb begin
      ram_wr_en    = wr_en;
      ram_wr_addr  = wr_addr;
      ram_wr_entry = wr_entry;
      if (clr_active_ff) begin
         ram_wr_en    = 1'b1;
         ram_wr_addr  = clr_idx_ff;
         ram_wr_entry = '0;
      end
   end

   // A read issued in the same cycle as a write to that index sees the new entry.
   assign byp_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_idx_ff    <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (rd_en) begin
         byp_ff <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         byp_entry_ff <= wr_entry;
      end
   end

   tpt_ram #(
      .WIDTH (MAP_ENTRY_W),
      .DEPTH (PAGE_COUNT)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = byp_ff ? byp_entry_ff : map_entry_type'(ram_rd_data);
   assign clearing = clr_active_ff;

endmodule

`default_nettype wire

[src/tpt_tlb.sv]
// ---------------------------------------------------------------------------
// TLB array
// Fully associative TLB, lowest matching slot wins, FIFO replacement.
// ---------------------------------------------------------------------------
`default_nettype none

module tpt_tlb #(
   parameter int TLB_ENTRIES = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [tpt_pkg::PAGE_W-1:0] lookup_page,
   input  wire tpt_pkg::tlb_fill_type      fill,
   output tpt_pkg::tlb_lookup_type         lookup
);
   import tpt_pkg::*;

   localparam int TLB_AW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

   logic [PAGE_W-1:0]  page_ff  [TLB_ENTRIES];
   logic [FRAME_W-1:0] frame_ff [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] valid_ff;
   logic [TLB_AW-1:0]  ptr_ff, ptr_in;

   // Scan from the top so the lowest matching slot ends up selected.
   always_comb begin
      lookup = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (page_ff[i] == lookup_page)) begin
            lookup.hit   = 1'b1;
            lookup.frame = frame_ff[i];
         end
      end
   end

   assign ptr_in = (ptr_ff == TLB_AW'(TLB_ENTRIES - 1)) ? '0 : ptr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
      end else if (fill.en) begin
         valid_ff[ptr_ff] <= 1'b1;
         ptr_ff           <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fill.en) begin
         page_ff[ptr_ff]  <= fill.page;
         frame_ff[ptr_ff] <= fill.frame;
      end
   end

endmodule

`default_nettype wire

[src/tlb_page_table_translator.sv]
// ---------------------------------------------------------------------------
// TLB page table translator
// Virtual to physical address translation through a FIFO TLB and page map.
// ---------------------------------------------------------------------------
// Translates one 16-bit virtual address per transfer (page in [15:8], offset
// in [7:0]) and sustains one transfer per cycle while rsp_stall is low. The
// first stage registers the address and reads the page map RAM, the second
// resolves the TLB compare, the page map entry and frame assignment and
// loads the result register. After reset, req_stall stays high while the
// page map is swept to all-invalid, one entry per cycle. A page fault grabs
// the next free frame and installs the mapping in both the page map and the
// TLB slot under the FIFO pointer; when frames run out the fault is flagged
// with out_of_frames, a zero address, and nothing installed. The three
// statistic counters saturate at all ones.
// ---------------------------------------------------------------------------
`default_nettype none
`include "tlb_page_table_translator_defines.svh"

module tlb_page_table_translator #(
   parameter int TLB_ENTRIES = 16,
   parameter int PAGE_COUNT  = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [tpt_pkg::VA_W-1:0]      req_virtual_address,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [tpt_pkg::VA_W-1:0]           rsp_physical_address,
   output logic [tpt_pkg::FRAME_W-1:0]        rsp_frame_number,
   output logic                               rsp_tlb_hit,
   output logic                               rsp_page_fault,
   output logic                               rsp_out_of_frames,
   output logic [tpt_pkg::CNT_W-1:0]          rsp_translated_count,
   output logic [tpt_pkg::CNT_W-1:0]          rsp_fault_count,
   output logic [tpt_pkg::CNT_W-1:0]          rsp_hit_count
);
   import tpt_pkg::*;

   localparam int MAP_AW      = $clog2(PAGE_COUNT);
   localparam int FRAME_LIMIT = (PAGE_COUNT < FRAME_SPAN) ? PAGE_COUNT : FRAME_SPAN;
   localparam int MAX_QUOT    = PAGE_SPAN / PAGE_COUNT;

   // Page number folded onto the map: parallel compares against each
   // multiple of PAGE_COUNT, then one subtract.
   function automatic logic [MAP_AW-1:0] map_index(input logic [PAGE_W-1:0] page);
      int base;
      base = 0;
      for (int k = 1; k <= MAX_QUOT; k++) begin
         if (int'(page) >= k * PAGE_COUNT) begin
            base = k * PAGE_COUNT;
         end
      end
      return MAP_AW'(int'(page) - base);
   endfunction

   // --- stage 1: accepted address, page map read in flight ---------------
   logic              vld_ff, vld_in;
   logic [VA_W-1:0]   va_ff;
   logic [MAP_AW-1:0] idx_ff, idx_in;

   // --- architectural state ----------------------------------------------
   logic [NFF_W-1:0]  nff_ff, nff_in;
   logic [CNT_W-1:0]  translations_ff, translations_in;
   logic [CNT_W-1:0]  faults_ff, faults_in;
   logic [CNT_W-1:0]  hits_ff, hits_in;

   // --- response register ------------------------------------------------
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VA_W-1:0]   rsp_physical_address_ff, rsp_physical_address_in;
   logic [FRAME_W-1:0] rsp_frame_number_ff, rsp_frame_number_in;
   logic              rsp_tlb_hit_ff, rsp_page_fault_ff, rsp_out_of_frames_ff;

   logic              accept, advance, map_clearing;
   logic [PAGE_W-1:0] page;
   logic [OFFSET_W-1:0] offset;
   tlb_lookup_type    tlb_res;
   tlb_fill_type      tlb_fill;
   map_entry_type     map_entry, map_wr_entry;
   logic              map_wr_en;
   logic              miss, fault, no_frame;
   logic [FRAME_W-1:0] frame;

   // Stage moves on when the response register is empty or being drained.
   assign advance   = vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = map_clearing || (vld_ff && !advance);
   assign accept    = req_valid && !req_stall;
   assign idx_in    = map_index(req_virtual_address[VA_W-1 -: PAGE_W]);

   always_comb begin
      vld_in = vld_ff;
      if (accept) begin
         vld_in = 1'b1;
      end else if (advance) begin
         vld_in = 1'b0;
      end
   end

   assign page   = va_ff[VA_W-1 -: PAGE_W];
   assign offset = va_ff[OFFSET_W-1:0];

   tpt_tlb #(
      .TLB_ENTRIES (TLB_ENTRIES)
   ) u_tlb (
      .clock       (clock),
      .reset       (reset),
      .lookup_page (page),
      .fill        (tlb_fill),
      .lookup      (tlb_res)
   );

   tpt_pmap #(
      .PAGE_COUNT (PAGE_COUNT)
   ) u_pmap (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (idx_in),
      .wr_en    (map_wr_en),
      .wr_addr  (idx_ff),
      .wr_entry (map_wr_entry),
      .rd_entry (map_entry),
      .clearing (map_clearing)
   );

   // --- stage 2: resolve the translation ---------------------------------
   assign miss     = !tlb_res.hit;
   assign fault    = miss && !map_entry.valid;
   assign no_frame = fault && (nff_ff >= NFF_W'(FRAME_LIMIT));

   always_comb begin
      if (tlb_res.hit) begin
         frame = tlb_res.frame;
      end else if (no_frame) begin
         frame = '0;
      end else if (fault) begin
         frame = nff_ff[FRAME_W-1:0];
      end else begin
         frame = map_entry.frame;
      end
   end

   // New mapping goes into the page map only on a serviced fault.
   assign map_wr_en          = advance && fault && !no_frame;
   assign map_wr_entry.valid = 1'b1;
   assign map_wr_entry.frame = nff_ff[FRAME_W-1:0];

   // Every serviced miss refills the FIFO slot.
   assign tlb_fill.en    = advance && miss && !no_frame;
   assign tlb_fill.page  = page;
   assign tlb_fill.frame = frame;

   assign nff_in          = map_wr_en ? nff_ff + 1'b1 : nff_ff;
   assign translations_in = (translations_ff == '1) ? translations_ff
                                                    : translations_ff + 1'b1;
   assign faults_in       = (fault && faults_ff != '1) ? faults_ff + 1'b1 : faults_ff;
   assign hits_in         = (tlb_res.hit && hits_ff != '1) ? hits_ff + 1'b1 : hits_ff;

   assign rsp_physical_address_in = no_frame ? '0 : {frame, offset};
   assign rsp_frame_number_in     = frame;
   assign rsp_valid_in            = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         nff_ff          <= '0;
         translations_ff <= '0;
         faults_ff       <= '0;
         hits_ff         <= '0;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            nff_ff          <= nff_in;
            translations_ff <= translations_in;
            faults_ff       <= faults_in;
            hits_ff         <= hits_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         va_ff  <= req_virtual_address;
         idx_ff <= idx_in;
      end
      if (advance) begin
         rsp_physical_address_ff <= rsp_physical_address_in;
         rsp_frame_number_ff     <= rsp_frame_number_in;
         rsp_tlb_hit_ff          <= tlb_res.hit;
         rsp_page_fault_ff       <= fault;
         rsp_out_of_frames_ff    <= no_frame;
      end
   end

   // Counters register the post-increment values, so they double as outputs.
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_physical_address_ff;
   assign rsp_frame_number     = rsp_frame_number_ff;
   assign rsp_tlb_hit          = rsp_tlb_hit_ff;
   assign rsp_page_fault       = rsp_page_fault_ff;
   assign rsp_out_of_frames    = rsp_out_of_frames_ff;
   assign rsp_translated_count = translations_ff;
   assign rsp_fault_count      = faults_ff;
   assign rsp_hit_count        = hits_ff;

   // --- checks -------------------------------------------------------------
   `TPT_ASSERT_NEVER(a_hit_and_fault, clock, reset,
      rsp_valid_ff && rsp_tlb_hit_ff && rsp_page_fault_ff, "TLB hit reported with fault")
   `TPT_ASSERT(a_oof_shape, clock, reset,
      (rsp_valid_ff && rsp_out_of_frames_ff) |-> (rsp_page_fault_ff && rsp_physical_address_ff == '0 && rsp_frame_number_ff == '0),
      "out_of_frames without fault or with nonzero address")
   `TPT_ASSERT_NEVER(a_frame_limit, clock, reset,
      nff_ff > NFF_W'(FRAME_LIMIT), "free-frame counter past the frame limit")
   `TPT_ASSERT_NEVER(a_hits_bounded, clock, reset,
      (hits_ff > translations_ff) || (faults_ff > translations_ff), "counter exceeds translations")
   `TPT_ASSERT_NEVER(a_busy_while_clearing, clock, reset,
      map_clearing && vld_ff, "translation in flight during page map sweep")

endmodule

`default_nettype wire

[tb/tlb_translation_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TLB translation checker
// Watches both channels of the translator, predicts each translation from its
// own TLB and page map copy, and compares every result transfer in order.
// ---------------------------------------------------------------------------
module tlb_translation_checker #(
   parameter int TLB_ENTRIES = 16,
   parameter int PAGE_COUNT  = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [tpt_pkg::VA_W-1:0]    req_virtual_address,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [tpt_pkg::VA_W-1:0]    rsp_physical_address,
   input  logic [tpt_pkg::FRAME_W-1:0] rsp_frame_number,
   input  logic                       rsp_tlb_hit,
   input  logic                       rsp_page_fault,
   input  logic                       rsp_out_of_frames,
   input  logic [tpt_pkg::CNT_W-1:0]   rsp_translated_count,
   input  logic [tpt_pkg::CNT_W-1:0]   rsp_fault_count,
   input  logic [tpt_pkg::CNT_W-1:0]   rsp_hit_count,
   output int                         mismatch_count,
   output int                         pending_count
);
   import tpt_pkg::*;

   localparam int FRAME_LIMIT  = (PAGE_COUNT < FRAME_SPAN) ? PAGE_COUNT : FRAME_SPAN;
   localparam int REPORT_LINES = 40;

   typedef struct packed {
      logic [VA_W-1:0]    va;
      logic [VA_W-1:0]    phys;
      logic [FRAME_W-1:0] frame;
      logic               hit;
      logic               fault;
      logic               no_frame;
      logic [CNT_W-1:0]   translated;
      logic [CNT_W-1:0]   faults;
      logic [CNT_W-1:0]   hits;
   } translation_type;

   translation_type expected_translations[$];

   logic [PAGE_W-1:0]  cached_page[TLB_ENTRIES];
   logic [FRAME_W-1:0] cached_frame[TLB_ENTRIES];
   logic               cached_valid[TLB_ENTRIES];
   map_entry_type      map_table[PAGE_COUNT];
   int                 fill_slot;
   int                 free_frame;
   logic [CNT_W-1:0]   xlate_total;
   logic [CNT_W-1:0]   fault_total;
   logic [CNT_W-1:0]   hit_total;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] value);
      return (value == '1) ? value : value + 1'b1;
   endfunction

   task automatic report_failure(input string msg);
      if (mismatch_count < REPORT_LINES)
         $display("%0t ns  MISMATCH  %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic predict_translation(input logic [VA_W-1:0] va, output translation_type res);
      logic [PAGE_W-1:0]   page;
      logic [OFFSET_W-1:0] offset;
      int                  map_idx;
      logic [FRAME_W-1:0]  frame;
      logic                hit;
      logic                fault;
      logic                no_frame;
      page     = va[VA_W-1:OFFSET_W];
      offset   = va[OFFSET_W-1:0];
      map_idx  = int'(page) % PAGE_COUNT;
      frame    = '0;
      hit      = 1'b0;
      fault    = 1'b0;
      no_frame = 1'b0;
      xlate_total = bump(xlate_total);
      // lowest matching valid entry wins
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         if (!hit && cached_valid[i] && cached_page[i] == page) begin
            hit   = 1'b1;
            frame = cached_frame[i];
         end
      end
      if (hit) begin
         hit_total = bump(hit_total);
      end else begin
         if (!map_table[map_idx].valid) begin
            fault       = 1'b1;
            fault_total = bump(fault_total);
            if (free_frame >= FRAME_LIMIT) begin
               no_frame = 1'b1;
            end else begin
               map_table[map_idx].valid = 1'b1;
               map_table[map_idx].frame = free_frame[FRAME_W-1:0];
               free_frame++;
            end
         end
         if (!no_frame) begin
            frame                   = map_table[map_idx].frame;
            cached_page[fill_slot]  = page;
            cached_frame[fill_slot] = frame;
            cached_valid[fill_slot] = 1'b1;
            fill_slot               = (fill_slot + 1) % TLB_ENTRIES;
         end
      end
      res.va         = va;
      res.phys       = no_frame ? '0 : {frame, offset};
      res.frame      = frame;
      res.hit        = hit;
      res.fault      = fault;
      res.no_frame   = no_frame;
      res.translated = xlate_total;
      res.faults     = fault_total;
      res.hits       = hit_total;
   endtask

   always @(posedge clock) begin
      translation_type want;
      if (reset) begin
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            cached_page[i]  = '0;
            cached_frame[i] = '0;
            cached_valid[i] = 1'b0;
         end
         for (int i = 0; i < PAGE_COUNT; i++)
            map_table[i] = '0;
         fill_slot   = 0;
         free_frame  = 0;
         xlate_total = '0;
         fault_total = '0;
         hit_total   = '0;
         expected_translations.delete();
      end else begin
         if (req_valid && !req_stall) begin
            predict_translation(req_virtual_address, want);
            expected_translations.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_translations.size() == 0) begin
               report_failure($sformatf("result with nothing pending, physical_address %h",
                                        rsp_physical_address));
            end else begin
               want = expected_translations.pop_front();
               if (rsp_physical_address !== want.phys)
                  report_failure($sformatf("va %h: physical_address got %h want %h",
                                           want.va, rsp_physical_address, want.phys));
               if (rsp_frame_number !== want.frame)
                  report_failure($sformatf("va %h: frame_number got %h want %h",
                                           want.va, rsp_frame_number, want.frame));
               if (rsp_tlb_hit !== want.hit)
                  report_failure($sformatf("va %h: tlb_hit got %b want %b",
                                           want.va, rsp_tlb_hit, want.hit));
               if (rsp_page_fault !== want.fault)
                  report_failure($sformatf("va %h: page_fault got %b want %b",
                                           want.va, rsp_page_fault, want.fault));
               if (rsp_out_of_frames !== want.no_frame)
                  report_failure($sformatf("va %h: out_of_frames got %b want %b",
                                           want.va, rsp_out_of_frames, want.no_frame));
               if (rsp_translated_count !== want.translated)
                  report_failure($sformatf("va %h: translated_count got %h want %h",
                                           want.va, rsp_translated_count, want.translated));
               if (rsp_fault_count !== want.faults)
                  report_failure($sformatf("va %h: fault_count got %h want %h",
                                           want.va, rsp_fault_count, want.faults));
               if (rsp_hit_count !== want.hits)
                  report_failure($sformatf("va %h: hit_count got %h want %h",
                                           want.va, rsp_hit_count, want.hits));
            end
         end
      end
      pending_count = expected_translations.size();
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TLB page table translator testbench
// Drives virtual addresses through the translator under three idle/stall
// mixes; the checker beside the block predicts and compares every transfer.
// ---------------------------------------------------------------------------
module testbench;
   import tpt_pkg::*;

   localparam int TLB_DEPTH     = 16;
   localparam int MAP_DEPTH     = 256;
   localparam int PHASE_ITEMS   = 450;
   localparam int DRAIN_CYCLES  = 10;
   // Worst case: reset, page map sweep, then every transfer paying a long
   // sender gap and a long receiver stall. Several times over that.
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HISTORY_DEPTH = 64;
   localparam int HOT_DEPTH     = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid           = 1'b0;
   logic                 req_stall;
   logic [VA_W-1:0]      req_virtual_address = '0;
   logic                 rsp_valid;
   logic                 rsp_stall           = 1'b0;
   logic [VA_W-1:0]      rsp_physical_address;
   logic [FRAME_W-1:0]   rsp_frame_number;
   logic                 rsp_tlb_hit;
   logic                 rsp_page_fault;
   logic                 rsp_out_of_frames;
   logic [CNT_W-1:0]     rsp_translated_count;
   logic [CNT_W-1:0]     rsp_fault_count;
   logic [CNT_W-1:0]     rsp_hit_count;

   int mismatch_count;
   int pending_translations;
   int cycle_count = 0;

   // Idle odds in percent per cycle, switched per phase.
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;

   // Pages sent so far: a short history for TLB hits and page map hits, and
   // a used map so fresh pages keep faulting until every frame is taken.
   logic [PAGE_W-1:0] recent_pages[$];
   bit                page_used[PAGE_SPAN];

   initial begin
      forever #5 clock = ~clock;
   end

   tlb_page_table_translator #(
      .TLB_ENTRIES (TLB_DEPTH),
      .PAGE_COUNT  (MAP_DEPTH)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_virtual_address  (req_virtual_address),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_physical_address (rsp_physical_address),
      .rsp_frame_number     (rsp_frame_number),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_out_of_frames    (rsp_out_of_frames),
      .rsp_translated_count (rsp_translated_count),
      .rsp_fault_count      (rsp_fault_count),
      .rsp_hit_count        (rsp_hit_count)
   );

   tlb_translation_checker #(
      .TLB_ENTRIES (TLB_DEPTH),
      .PAGE_COUNT  (MAP_DEPTH)
   ) i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_virtual_address  (req_virtual_address),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_physical_address (rsp_physical_address),
      .rsp_frame_number     (rsp_frame_number),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_out_of_frames    (rsp_out_of_frames),
      .rsp_translated_count (rsp_translated_count),
      .rsp_fault_count      (rsp_fault_count),
      .rsp_hit_count        (rsp_hit_count),
      .mismatch_count       (mismatch_count),
      .pending_count        (pending_translations)
   );

   // Receiver back-pressure: a fresh coin per cycle at the phase's odds.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // One request transfer. An optional idle gap comes first, then the
   // address is held with valid high until the block takes it. Exactly one
   // nonblocking write to req_valid per clock step.
   task automatic send_translation(input logic [VA_W-1:0] va);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < req_idle_pct) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_virtual_address <= va;
      @(posedge clock);
      // req_stall is high through the page map sweep after reset too
      while (req_stall) @(posedge clock);
      recent_pages.push_back(va[VA_W-1:OFFSET_W]);
      if (recent_pages.size() > HISTORY_DEPTH) void'(recent_pages.pop_front());
      page_used[va[VA_W-1:OFFSET_W]] = 1'b1;
   endtask

   initial begin
      int                req_plan[3];
      int                rsp_plan[3];
      int                pick;
      int                idx;
      int                depth;
      logic [PAGE_W-1:0] page;

      req_plan = '{10, 73, 0};
      rsp_plan = '{73, 10, 0};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct  = req_plan[0];
      rsp_stall_pct = rsp_plan[0];

      // Directed part.
      // Page 0 on a fresh TLB: cleared tags read zero but must not hit.
      send_translation(16'h0000);
      send_translation(16'h00FF);            // now a hit, top offset
      send_translation(16'hFF00);            // top page faults into frame 1
      send_translation(16'hFFFF);            // hit, all ones
      // Fill the remaining slots, then one more so the FIFO pointer wraps
      // and the oldest entry (page 0) is evicted.
      for (int p = 1; p <= 14; p++)
         send_translation({p[7:0], 8'(p * 17)});
      send_translation(16'h80A5);
      send_translation(16'h0012);            // TLB miss, page map still valid
      send_translation(16'hFF5A);            // page FF was just evicted too
      send_translation(16'hAA55);
      send_translation(16'h55AA);

      // Random part: three idling mixes. Per item, pick a hot page (likely
      // TLB hit), a warm page (likely TLB miss with a page map hit) or a
      // fresh page (fault) so the map fills and frames run out mid-run.
      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct  = req_plan[phase];
         rsp_stall_pct = rsp_plan[phase];
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               depth = (recent_pages.size() < HOT_DEPTH) ? recent_pages.size() : HOT_DEPTH;
               page  = recent_pages[recent_pages.size() - 1 - $urandom_range(depth - 1)];
            end else if (pick < 70) begin
               page = recent_pages[$urandom_range(recent_pages.size() - 1)];
            end else begin
               idx = $urandom_range(PAGE_SPAN - 1);
               for (int k = 0; k < PAGE_SPAN && page_used[idx]; k++)
                  idx = (idx + 1) % PAGE_SPAN;
               page = idx[PAGE_W-1:0];
            end
            send_translation({page, 8'($urandom_range(255))});
         end
      end
      req_valid <= 1'b0;

      // Let the checker log the last request before looking at the backlog.
      @(posedge clock);
      wait (pending_translations == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);

      if (mismatch_count == 0 && pending_translations == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
